[rtl/vpdd_pkg.sv]
// vpdd_pkg: shared types, codes and the per-function result sequence for the packet deframer
// no dependencies; used by vpdd_assemble and vision_packet_deframe_decode
package vpdd_pkg;

    localparam logic [7:0] START_BYTE      = 8'hFD;
    localparam logic [7:0] END_BYTE        = 8'hFE;
    localparam logic [7:0] FILL_BYTE       = 8'hFF;
    localparam logic [7:0] FUNC_NULL       = 8'h00;
    localparam logic [7:0] FUNC_OBJNUM     = 8'h46;
    localparam logic [7:0] FUNC_TAG        = 8'd10;
    localparam logic [7:0] FUNC_LANES      = 8'd16;
    localparam logic [7:0] FUNC_DIGITS     = 8'd17;
    localparam logic [7:0] FUNC_CLASSIFIER = 8'd18;
    localparam logic [7:0] FUNC_DRIVING    = 8'd20;
    localparam logic [7:0] MIN_LEN         = 8'd3;
    localparam logic [7:0] EXPR_LEN_BASE   = 8'd17;
    localparam logic [4:0] EXPR_MAX        = 5'd16;
    localparam logic [5:0] EXPR_START      = 6'd15;
    localparam logic [5:0] DRV_MODE_ADDR   = 6'd18;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_LEN_SHORT = 3'd1;
    localparam logic [2:0] ST_LEN_LONG  = 3'd2;
    localparam logic [2:0] ST_BAD_END   = 3'd3;
    localparam logic [2:0] ST_BAD_SUM   = 3'd4;
    localparam logic [2:0] ST_NULL_FUNC = 3'd5;

    localparam logic [4:0] CODE_NONE   = 5'd0;
    localparam logic [4:0] CODE_TYPE   = 5'd1;
    localparam logic [4:0] CODE_X      = 5'd2;
    localparam logic [4:0] CODE_Y      = 5'd3;
    localparam logic [4:0] CODE_ANSWER = 5'd6;
    localparam logic [4:0] CODE_EXPR   = 5'd7;
    localparam logic [4:0] CODE_POSE0  = 5'd8;
    localparam logic [4:0] CODE_LANE0  = 5'd16;

    typedef enum logic [2:0] {
        K_RAW,
        K_U16,
        K_W16,
        K_W16H,
        K_DEC,
        K_DRV_T,
        K_DRV_XY
    } t_kind;

    typedef struct packed {
        logic [4:0] code;
        logic [5:0] addr;
        logic [3:0] nbytes;
        t_kind      kind;
        logic       last;
    } t_step;

    typedef struct packed {
        logic  load_first;
        logic  load_next;
        t_kind kind;
    } t_asm_ctl;

    function automatic t_step step_info(input logic [7:0] func, input logic [4:0] step,
                                        input logic [7:0] len);
        t_step      st;
        logic [4:0] total;
        logic [4:0] nexpr;
        logic [7:0] extra;
        st.kind   = K_RAW;
        st.nbytes = 4'd1;
        st.code   = CODE_NONE;
        st.addr   = 6'd0;
        total     = 5'd5;
        nexpr     = 5'd0;
        extra     = 8'd0;
        case (func)
            FUNC_DIGITS: begin
                if (len > EXPR_LEN_BASE) begin
                    extra = len - EXPR_LEN_BASE;
                    nexpr = (extra > 8'(EXPR_MAX)) ? EXPR_MAX : 5'(extra);
                end
                total = 5'd5 + nexpr;
                if (step < 5'd4) begin
                    st.code = step + CODE_X;
                    st.addr = 6'(step) + 6'd3;
                end else if (step == 5'd4) begin
                    st.code   = CODE_ANSWER;
                    st.addr   = 6'd7;
                    st.nbytes = 4'd8;
                    st.kind   = K_DEC;
                end else begin
                    st.code = CODE_EXPR;
                    st.addr = 6'(step) + EXPR_START - 6'd5;
                end
            end
            FUNC_LANES: begin
                total   = 5'd10;
                st.addr = 6'(step) + 6'd3;
                st.code = (step < 5'd2) ? step + CODE_X : step - 5'd2 + CODE_LANE0;
            end
            FUNC_CLASSIFIER: begin
                total = 5'd5;
                if (step == 5'd0) begin
                    st.code   = CODE_TYPE;
                    st.addr   = 6'd3;
                    st.nbytes = 4'd2;
                    st.kind   = K_U16;
                end else begin
                    st.code = step + CODE_TYPE;
                    st.addr = 6'(step) + 6'd4;
                end
            end
            FUNC_DRIVING: begin
                total     = 5'd3;
                st.nbytes = 4'd2;
                if (step == 5'd0) begin
                    st.code = CODE_TYPE;
                    st.addr = 6'd13;
                    st.kind = K_DRV_T;
                end else begin
                    st.code = step + CODE_TYPE;
                    st.addr = 6'(step) + 6'd2;
                    st.kind = K_DRV_XY;
                end
            end
            default: begin
                total = (func == FUNC_TAG) ? 5'd13 : 5'd5;
                if (step < 5'd5) begin
                    st.code = step + CODE_TYPE;
                    st.addr = 6'(step) + 6'd3;
                end else begin
                    st.code   = step - 5'd5 + CODE_POSE0;
                    st.addr   = 6'({step, 1'b0}) - 6'd2;
                    st.nbytes = 4'd2;
                    st.kind   = (step < 5'd8) ? K_W16 : K_W16H;
                end
            end
        endcase
        st.last = (step == total - 5'd1);
        return st;
    endfunction

endpackage

[rtl/vpdd_assemble.sv]
// vpdd_assemble: gathers the bytes of one result and forms its signed value
// depends on vpdd_pkg (t_asm_ctl, t_kind)
module vpdd_assemble (
    input  logic                 i_clk,
    input  vpdd_pkg::t_asm_ctl   i_ctl,
    input  logic [7:0]           i_byte,
    output logic signed [29:0]   o_value
);

    logic [7:0]  r_b0;
    logic [7:0]  r_b1;
    logic [28:0] r_acc;
    logic [15:0] word;
    logic signed [23:0] word_x100;
    logic [29:0] acc_ext;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_first) begin
            r_b0  <= i_byte;
            r_acc <= '0;
        end else if (i_ctl.load_next) begin
            r_b1  <= i_byte;
            r_acc <= 29'((32'(r_acc) << 3) + (32'(r_acc) << 1) + 32'(i_byte));
        end
    end

    assign word      = {r_b0, r_b1};
    assign word_x100 = $signed({{8{word[15]}}, word}) * 24'sd100;
    assign acc_ext   = {1'b0, r_acc};

    always_comb begin
        case (i_ctl.kind)
            vpdd_pkg::K_RAW:   o_value = $signed(30'(r_b0));
            vpdd_pkg::K_U16:   o_value = $signed(30'(word));
            vpdd_pkg::K_W16:   o_value = $signed({{14{word[15]}}, word});
            vpdd_pkg::K_W16H:  o_value = $signed({{6{word_x100[23]}}, word_x100});
            vpdd_pkg::K_DEC:   o_value = (r_b0 == 8'd0) ? $signed(-acc_ext) : $signed(acc_ext);
            vpdd_pkg::K_DRV_T: o_value = (r_b1 == 8'd0 || r_b1 == 8'd1) ? $signed('1)
                                                                         : $signed(30'(r_b0));
            vpdd_pkg::K_DRV_XY: o_value = (r_b1 == 8'd0 || r_b1 == 8'd2) ? $signed('1)
                                                                          : $signed(30'(r_b0));
            default:           o_value = '0;
        endcase
    end

endmodule

[rtl/vision_packet_deframe_decode.sv]
// vision_packet_deframe_decode: packet deframer, checker and field decoder for a vision link
// depends on vpdd_pkg and vpdd_assemble; packet bytes live in a one-port-read buffer
//
//  channel | direction | handshake                  | payload
//  rx      | in        | i_rx_valid / o_rx_ready    | i_rx_byte
//  res     | out       | o_res_valid / i_res_ready  | o_status o_func_id o_field_code
//          |           |                            | o_field_value o_last
//
// a failed check loads its result into the output register as the failing word is taken
// a decoded packet then emits its run: each result is issued, read from the buffer one byte
// at a time, then emitted once the output slot is free; the longest run is function 17, 16 characters
// rx is held off while a run is emitted and while the output register is full and not being read
// synchronous active-low reset returns to hunting for the start byte; no clearing pass
module vision_packet_deframe_decode #(
    parameter int PACKET_MAX = 33
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rx_valid,
    output logic               o_rx_ready,
    input  logic [7:0]         i_rx_byte,
    output logic               o_res_valid,
    input  logic               i_res_ready,
    output logic [2:0]         o_status,
    output logic [7:0]         o_func_id,
    output logic [4:0]         o_field_code,
    output logic signed [29:0] o_field_value,
    output logic               o_last
);

    localparam int AW = $clog2(PACKET_MAX);
    localparam logic [7:0] PMAX8 = 8'(PACKET_MAX);
    localparam logic [6:0] PMAX7 = 7'(PACKET_MAX);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_READ  = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic        r_collect;
    logic [5:0]  r_idx;
    logic [7:0]  r_len;
    logic [7:0]  r_sum;
    logic [7:0]  r_func;
    logic [7:0]  r_prev;
    logic [4:0]  r_step;

    vpdd_pkg::t_step r_info;
    vpdd_pkg::t_step step_now;
    logic [5:0]  r_raddr;
    logic [3:0]  r_left;
    logic        r_first;
    logic        r_rdff;

    logic [7:0]  mem [PACKET_MAX];
    logic [7:0]  r_mem_q;

    logic        r_ovalid;
    logic [2:0]  r_status;
    logic [7:0]  r_ofunc;
    logic [4:0]  r_code;
    logic signed [29:0] r_value;
    logic        r_last;

    logic        rx_fire;
    logic        slot_free;
    logic [7:0]  idx_ext;
    logic        err_load;
    logic [2:0]  err_status;
    logic [7:0]  err_func;
    logic        finish;
    logic        start_dec;
    logic        wr_en;
    logic        issue;
    logic [5:0]  rd_addr;
    logic        rd_hit;
    vpdd_pkg::t_kind rd_kind;
    logic [5:0]  rd_next;
    logic        emit;
    logic [7:0]  rd_byte;
    vpdd_pkg::t_asm_ctl asm_ctl;
    logic signed [29:0] asm_value;

    assign slot_free  = !r_ovalid || i_res_ready;
    assign o_rx_ready = (r_state == S_IDLE) && slot_free;
    assign rx_fire    = i_rx_valid && o_rx_ready;
    assign idx_ext    = {2'b00, r_idx};

    // deframing decisions on the incoming word
    always_comb begin
        err_load   = 1'b0;
        err_status = vpdd_pkg::ST_OK;
        err_func   = i_rx_byte;
        finish     = 1'b0;
        start_dec  = 1'b0;
        if (rx_fire && r_collect && r_idx > 6'd1) begin
            if (r_idx == 6'd2 && r_len <= vpdd_pkg::MIN_LEN) begin
                err_load   = 1'b1;
                err_status = vpdd_pkg::ST_LEN_SHORT;
                finish     = 1'b1;
            end else if (r_idx == 6'd2 && r_len > PMAX8) begin
                err_load   = 1'b1;
                err_status = vpdd_pkg::ST_LEN_LONG;
                finish     = 1'b1;
            end else if (!(idx_ext + 8'd1 < r_len)) begin
                finish   = 1'b1;
                err_func = r_func;
                if (i_rx_byte != vpdd_pkg::END_BYTE) begin
                    err_load   = 1'b1;
                    err_status = vpdd_pkg::ST_BAD_END;
                end else if (r_sum != r_prev) begin
                    err_load   = 1'b1;
                    err_status = vpdd_pkg::ST_BAD_SUM;
                end else if (r_func == vpdd_pkg::FUNC_NULL) begin
                    err_load   = 1'b1;
                    err_status = vpdd_pkg::ST_NULL_FUNC;
                end else if (r_func != vpdd_pkg::FUNC_OBJNUM) begin
                    start_dec = 1'b1;
                end
            end
        end
    end

    assign wr_en = rx_fire && (r_collect ? ({1'b0, r_idx} < PMAX7)
                                         : (i_rx_byte == vpdd_pkg::START_BYTE));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_collect <= 1'b0;
            r_idx     <= '0;
            r_len     <= '0;
            r_sum     <= '0;
        end else if (rx_fire) begin
            if (!r_collect) begin
                if (i_rx_byte == vpdd_pkg::START_BYTE) begin
                    r_collect <= 1'b1;
                    r_idx     <= 6'd1;
                    r_len     <= '0;
                    r_sum     <= '0;
                end
            end else if (r_idx <= 6'd1) begin
                r_len <= i_rx_byte;
                r_sum <= i_rx_byte;
                r_idx <= 6'd2;
            end else if (finish) begin
                r_collect <= 1'b0;
                r_idx     <= '0;
            end else begin
                if (idx_ext + 8'd3 <= r_len) begin
                    r_sum <= r_sum + i_rx_byte;
                end
                r_idx <= r_idx + 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rx_fire && r_collect) begin
            r_prev <= i_rx_byte;
            if (r_idx == 6'd2) begin
                r_func <= i_rx_byte;
            end
        end
    end

    // packet buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_collect ? r_idx[AW-1:0] : '0] <= i_rx_byte;
        end
    end

    assign step_now = vpdd_pkg::step_info(r_func, r_step, r_len);

    always_comb begin
        issue   = 1'b0;
        rd_addr = r_raddr;
        rd_kind = r_info.kind;
        if (r_state == S_ISSUE) begin
            issue   = 1'b1;
            rd_addr = step_now.addr;
            rd_kind = step_now.kind;
        end else if (r_state == S_READ && r_left != 4'd0) begin
            issue = 1'b1;
        end
    end

    assign rd_hit  = {2'b00, rd_addr} < r_len;
    assign rd_next = (rd_kind == vpdd_pkg::K_DRV_T || rd_kind == vpdd_pkg::K_DRV_XY)
                     ? vpdd_pkg::DRV_MODE_ADDR : rd_addr + 6'd1;

    always_ff @(posedge i_clk) begin
        if (issue && rd_hit) begin
            r_mem_q <= mem[rd_addr[AW-1:0]];
        end
    end

    assign rd_byte = r_rdff ? vpdd_pkg::FILL_BYTE : r_mem_q;
    assign emit    = (r_state == S_EMIT) && slot_free;

    always_comb begin
        asm_ctl.load_first = (r_state == S_READ) && r_first;
        asm_ctl.load_next  = (r_state == S_READ) && !r_first;
        asm_ctl.kind       = r_info.kind;
    end

    vpdd_assemble u_assemble (
        .i_clk   (i_clk),
        .i_ctl   (asm_ctl),
        .i_byte  (rd_byte),
        .o_value (asm_value)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (start_dec) n_state = S_ISSUE;
            S_ISSUE: n_state = S_READ;
            S_READ:  if (r_left == 4'd0) n_state = S_EMIT;
            S_EMIT:  if (emit) n_state = r_info.last ? S_IDLE : S_ISSUE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (start_dec) begin
                r_step <= '0;
            end else if (emit) begin
                r_step <= r_step + 5'd1;
            end
        end
    end

    // result sequencer datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_ISSUE) begin
            r_info  <= step_now;
            r_left  <= step_now.nbytes - 4'd1;
            r_first <= 1'b1;
        end else if (r_state == S_READ) begin
            r_first <= 1'b0;
            if (r_left != 4'd0) begin
                r_left <= r_left - 4'd1;
            end
        end
        if (issue) begin
            r_raddr <= rd_next;
            r_rdff  <= !rd_hit;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (err_load || emit) begin
            r_ovalid <= 1'b1;
        end else if (i_res_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (err_load) begin
            r_status <= err_status;
            r_ofunc  <= err_func;
            r_code   <= vpdd_pkg::CODE_NONE;
            r_value  <= '0;
            r_last   <= 1'b1;
        end else if (emit) begin
            r_status <= vpdd_pkg::ST_OK;
            r_ofunc  <= r_func;
            r_code   <= r_info.code;
            r_value  <= asm_value;
            r_last   <= r_info.last;
        end
    end

    assign o_res_valid   = r_ovalid;
    assign o_status      = r_status;
    assign o_func_id     = r_ofunc;
    assign o_field_code  = r_code;
    assign o_field_value = r_value;
    assign o_last        = r_last;

endmodule

[tb/sv/tb.sv]
// tb: self-checking bench for vision_packet_deframe_decode, one link byte per rx word
// predicts every result word from its own deframer and decoder and checks each field
// depends on vpdd_pkg and the rtl top level only
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PACKET_MAX   = 33;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int RANDOM_BYTES = 85;

    typedef logic [7:0] t_frame[$];

    typedef struct packed {
        logic [2:0]         status;
        logic [7:0]         func;
        logic [4:0]         code;
        logic signed [29:0] value;
        logic               last;
    } t_field_word;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_rx_valid    = 1'b0;
    logic               o_rx_ready;
    logic [7:0]         i_rx_byte     = 8'h00;
    logic               o_res_valid;
    logic               i_res_ready   = 1'b0;
    logic [2:0]         o_status;
    logic [7:0]         o_func_id;
    logic [4:0]         o_field_code;
    logic signed [29:0] o_field_value;
    logic               o_last;

    t_field_word decoded_fields_due[$];
    t_field_word packet_fields[$];
    logic [7:0]  frame_buf[PACKET_MAX];
    logic [5:0]  frame_idx   = '0;
    logic [7:0]  frame_len   = '0;
    logic [7:0]  frame_sum   = '0;
    logic        frame_open  = 1'b0;
    int          fail_count  = 0;
    int          cycle_count = 0;
    int          rx_calm     = 0;
    int          res_calm    = 0;

    vision_packet_deframe_decode #(
        .PACKET_MAX(PACKET_MAX)
    ) i_dut (
        .*
    );

    always #2 i_clk = ~i_clk;

    function automatic int draw_wait(ref int calm);
        if (calm > 0) begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    // bytes at or past the length read as fill
    function automatic logic [7:0] frame_byte(int k);
        if (k < int'(frame_len) && k < PACKET_MAX) begin
            return frame_buf[k];
        end
        return vpdd_pkg::FILL_BYTE;
    endfunction

    function automatic int word16(int k);
        logic signed [15:0] w;
        w = {frame_byte(k), frame_byte(k + 1)};
        return int'(w);
    endfunction

    function automatic void emit_field(logic [2:0] status, logic [7:0] func, logic [4:0] code,
                                       int value);
        t_field_word r;
        r.status = status;
        r.func   = func;
        r.code   = code;
        r.value  = value[29:0];
        r.last   = 1'b0;
        packet_fields.push_back(r);
    endfunction

    function automatic void close_frame();
        if (packet_fields.size() > 0) begin
            packet_fields[packet_fields.size() - 1].last = 1'b1;
        end
        foreach (packet_fields[i]) begin
            decoded_fields_due.push_back(packet_fields[i]);
        end
        frame_open = 1'b0;
        frame_idx  = '0;
    endfunction

    function automatic void decode_fields(logic [7:0] f);
        int         acc;
        int         n_expr;
        logic [7:0] mode;
        if (f == vpdd_pkg::FUNC_DIGITS) begin
            for (int k = 3; k <= 6; k++) begin
                emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_X + 5'(k - 3),
                           int'(frame_byte(k)));
            end
            acc = 0;
            for (int k = 8; k <= 14; k++) begin
                acc = acc * 10 + int'(frame_byte(k));
            end
            if (frame_byte(7) == 8'h00) begin
                acc = -acc;
            end
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_ANSWER, acc);
            n_expr = int'(frame_len) - int'(vpdd_pkg::EXPR_LEN_BASE);
            if (n_expr > int'(vpdd_pkg::EXPR_MAX)) begin
                n_expr = int'(vpdd_pkg::EXPR_MAX);
            end
            for (int k = 0; k < n_expr; k++) begin
                emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_EXPR,
                           int'(frame_byte(int'(vpdd_pkg::EXPR_START) + k)));
            end
        end else if (f == vpdd_pkg::FUNC_LANES) begin
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_X, int'(frame_byte(3)));
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_Y, int'(frame_byte(4)));
            for (int k = 0; k < 8; k++) begin
                emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_LANE0 + 5'(k),
                           int'(frame_byte(5 + k)));
            end
        end else if (f == vpdd_pkg::FUNC_CLASSIFIER) begin
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_TYPE,
                       int'(frame_byte(3)) * 256 + int'(frame_byte(4)));
            for (int k = 5; k <= 8; k++) begin
                emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_TYPE + 5'(k - 4),
                           int'(frame_byte(k)));
            end
        end else if (f == vpdd_pkg::FUNC_DRIVING) begin
            mode = frame_byte(int'(vpdd_pkg::DRV_MODE_ADDR));
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_TYPE,
                       (mode == 8'd0 || mode == 8'd1) ? -1 : int'(frame_byte(13)));
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_X,
                       (mode == 8'd0 || mode == 8'd2) ? -1 : int'(frame_byte(3)));
            emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_Y,
                       (mode == 8'd0 || mode == 8'd2) ? -1 : int'(frame_byte(4)));
        end else begin
            for (int k = 3; k <= 7; k++) begin
                emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_TYPE + 5'(k - 3),
                           int'(frame_byte(k)));
            end
            if (f == vpdd_pkg::FUNC_TAG) begin
                // positions already in hundredths, rotations and centres scaled up
                for (int k = 0; k < 8; k++) begin
                    emit_field(vpdd_pkg::ST_OK, f, vpdd_pkg::CODE_POSE0 + 5'(k),
                               (k < 3) ? word16(8 + 2 * k) : word16(8 + 2 * k) * 100);
                end
            end
        end
    endfunction

    function automatic void deframe_byte(logic [7:0] b);
        int         idx;
        int         len;
        logic [7:0] f;
        idx = int'(frame_idx);
        len = int'(frame_len);
        packet_fields.delete();
        if (!frame_open) begin
            if (b == vpdd_pkg::START_BYTE) begin
                frame_buf[0] = b;
                frame_idx    = 6'd1;
                frame_len    = '0;
                frame_sum    = '0;
                frame_open   = 1'b1;
            end
            return;
        end
        if (idx < PACKET_MAX) begin
            frame_buf[idx] = b;
        end
        if (idx <= 1) begin
            frame_len = b;
            frame_sum = b;
            frame_idx = 6'd2;
            return;
        end
        if (idx == 2 && len <= int'(vpdd_pkg::MIN_LEN)) begin
            emit_field(vpdd_pkg::ST_LEN_SHORT, b, vpdd_pkg::CODE_NONE, 0);
            close_frame();
            return;
        end
        if (idx == 2 && len > PACKET_MAX) begin
            emit_field(vpdd_pkg::ST_LEN_LONG, b, vpdd_pkg::CODE_NONE, 0);
            close_frame();
            return;
        end
        if (idx + 3 <= len) begin
            frame_sum = frame_sum + b;
        end
        if (idx + 1 < len) begin
            frame_idx = 6'(idx + 1);
            return;
        end
        f = frame_byte(2);
        if (frame_byte(len - 1) != vpdd_pkg::END_BYTE) begin
            emit_field(vpdd_pkg::ST_BAD_END, f, vpdd_pkg::CODE_NONE, 0);
        end else if (frame_sum != frame_byte(len - 2)) begin
            emit_field(vpdd_pkg::ST_BAD_SUM, f, vpdd_pkg::CODE_NONE, 0);
        end else if (f == vpdd_pkg::FUNC_NULL) begin
            emit_field(vpdd_pkg::ST_NULL_FUNC, f, vpdd_pkg::CODE_NONE, 0);
        end else if (f != vpdd_pkg::FUNC_OBJNUM) begin
            decode_fields(f);
        end
        close_frame();
    endfunction

    function automatic logic [7:0] link_byte();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return vpdd_pkg::START_BYTE;
            3: return vpdd_pkg::END_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] payload_byte(logic [7:0] f, int k, logic digits_max);
        if (f == vpdd_pkg::FUNC_DRIVING && k == int'(vpdd_pkg::DRV_MODE_ADDR)) begin
            return 8'($urandom_range(0, 3));
        end
        if (f == vpdd_pkg::FUNC_DIGITS && k == 7) begin
            return ($urandom_range(0, 1) == 0) ? 8'h00 : link_byte();
        end
        if (f == vpdd_pkg::FUNC_DIGITS && k >= 8 && k <= 14) begin
            if (digits_max) begin
                return 8'hFF;
            end
            return ($urandom_range(0, 3) == 0) ? link_byte() : 8'($urandom_range(0, 9));
        end
        return link_byte();
    endfunction

    // well-formed frame with a correct sum; at length 4 the sum overwrites the function
    function automatic t_frame build_frame(logic [7:0] f, int len, logic digits_max);
        t_frame     q;
        logic [7:0] sum;
        q.push_back(vpdd_pkg::START_BYTE);
        q.push_back(8'(len));
        q.push_back(f);
        for (int k = 3; k < len; k++) begin
            q.push_back(payload_byte(f, k, digits_max));
        end
        sum = '0;
        for (int k = 1; k <= len - 3; k++) begin
            sum = sum + q[k];
        end
        q[len - 2] = sum;
        q[len - 1] = vpdd_pkg::END_BYTE;
        return q;
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = draw_wait(rx_calm);
        if (gap > 0) begin
            i_rx_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        do @(posedge i_clk); while (!o_rx_ready);
        deframe_byte(b);
    endtask

    task automatic send_frame(input t_frame q);
        foreach (q[i]) begin
            send_byte(q[i]);
        end
    endtask

    task automatic test_hunt_noise();
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_length_limits();
        t_frame q;
        q = {vpdd_pkg::START_BYTE, vpdd_pkg::MIN_LEN, 8'h55};
        send_frame(q);
        q = {vpdd_pkg::START_BYTE, 8'(PACKET_MAX + 1), 8'hAA};
        send_frame(q);
        q = {vpdd_pkg::START_BYTE, 8'hFF, 8'h01};
        send_frame(q);
    endtask

    task automatic test_shortest_frame();
        send_frame(build_frame(vpdd_pkg::FUNC_TAG, 4, 1'b0));
    endtask

    task automatic test_frame_checks();
        t_frame q;
        q = build_frame(vpdd_pkg::FUNC_TAG, 4, 1'b0);
        q[3] = 8'h00;
        send_frame(q);
        q = build_frame(vpdd_pkg::FUNC_TAG, 4, 1'b0);
        q[2] = q[2] + 8'd1;
        send_frame(q);
        send_frame(build_frame(vpdd_pkg::FUNC_NULL, 5, 1'b0));
    endtask

    task automatic test_count_drop();
        send_frame(build_frame(vpdd_pkg::FUNC_OBJNUM, 5, 1'b0));
    endtask

    task automatic test_random_frames();
        t_frame     q;
        logic [7:0] f;
        int         len;
        int         full;
        int         pick;
        int         pos;
        int         bytes_sent;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 9))
                0: f = vpdd_pkg::FUNC_TAG;
                1: f = vpdd_pkg::FUNC_LANES;
                2, 3: f = vpdd_pkg::FUNC_DIGITS;
                4: f = vpdd_pkg::FUNC_CLASSIFIER;
                5: f = vpdd_pkg::FUNC_DRIVING;
                6: f = vpdd_pkg::FUNC_OBJNUM;
                7: f = vpdd_pkg::FUNC_NULL;
                default: f = 8'($urandom_range(0, 255));
            endcase
            case (f)
                vpdd_pkg::FUNC_DIGITS: full = 17;
                vpdd_pkg::FUNC_TAG: full = 26;
                vpdd_pkg::FUNC_LANES: full = 15;
                vpdd_pkg::FUNC_CLASSIFIER: full = 11;
                vpdd_pkg::FUNC_DRIVING: full = 21;
                default: full = 10;
            endcase
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(4, PACKET_MAX)
                                               : $urandom_range(full, PACKET_MAX);
            q = build_frame(f, len, $urandom_range(0, 7) == 0);
            pick = $urandom_range(0, 99);
            if (pick < 15) begin
                case ($urandom_range(0, 2))
                    0: begin
                        pos = $urandom_range(1, len - 1);
                        q[pos] = q[pos] ^ 8'(1 << $urandom_range(0, 7));
                    end
                    1: q[1] = 8'($urandom_range(0, 255));
                    default: begin
                        pos = $urandom_range(1, len - 2);
                        q = q[0:pos];
                    end
                endcase
            end else if (pick < 25) begin
                repeat ($urandom_range(1, 3)) q.push_front(link_byte());
            end
            send_frame(q);
            bytes_sent += q.size();
        end
    endtask

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial begin : result_sink
        t_field_word want;
        int          stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = draw_wait(res_calm);
            if (stall > 0) begin
                i_res_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_res_ready <= 1'b1;
            do @(posedge i_clk); while (!o_res_valid);
            if (decoded_fields_due.size() == 0) begin
                $error("unexpected result word: status %0d func %0d code %0d value %0d last %0d",
                       o_status, o_func_id, o_field_code, o_field_value, o_last);
                fail_count++;
            end else begin
                want = decoded_fields_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_func_id !== want.func) begin
                    $error("func_id: expected %0d, got %0d", want.func, o_func_id);
                    fail_count++;
                end
                if (o_field_code !== want.code) begin
                    $error("field_code: expected %0d, got %0d", want.code, o_field_code);
                    fail_count++;
                end
                if (o_field_value !== want.value) begin
                    $error("field_value: expected %0d, got %0d", want.value, o_field_value);
                    fail_count++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : stimulus
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_hunt_noise();
        test_length_limits();
        test_shortest_frame();
        test_frame_checks();
        test_count_drop();
        test_random_frames();
        i_rx_valid <= 1'b0;
        while (decoded_fields_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/vpdd_pkg.sv
rtl/vpdd_assemble.sv
rtl/vision_packet_deframe_decode.sv
tb/sv/tb.sv
